@@ rtl/core/drbr_pkg.sv @@
// Shared types, constants and helpers for the dirty-rectangle band restore block.
package drbr_pkg;

    // Geometry and list size
    localparam int LIST_DEPTH  = 8;
    localparam int ROW_BYTES   = 80;
    localparam int SCREEN_ROWS = 200;
    localparam int WIDTH_CAP   = 126;
    localparam int WIDTH_LIM   = ((ROW_BYTES / 2) * 2 > WIDTH_CAP) ? WIDTH_CAP
                                                                    : (ROW_BYTES / 2) * 2;

    // Field widths
    localparam int XB_W    = 7;
    localparam int ROW_W   = 8;
    localparam int WID_W   = 7;
    localparam int WORD_W  = 16;
    localparam int CIDX_W  = 3;
    localparam int NUM_CFG = 7;
    localparam int BAND_W  = 3;

    // Band boundaries (first row of each band)
    localparam int HUD_END         = 8;
    localparam int HIGH_SKY_END    = 64;
    localparam int MID_SKY_END     = 120;
    localparam int MOUNTAIN_TOP    = 199 - 29;
    localparam int GROUND_EDGE_ROW = 199 - 25;

    // Command codes
    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_RESTORE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_HUD         = 3'd0,
        CFG_HIGH_SKY    = 3'd1,
        CFG_MID_SKY     = 3'd2,
        CFG_LOW_SKY     = 3'd3,
        CFG_MOUNTAIN    = 3'd4,
        CFG_GROUND_EDGE = 3'd5,
        CFG_GROUND      = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // One stored rectangle
    typedef struct packed {
        logic [XB_W-1:0]  xbyte;
        logic [ROW_W-1:0] top;
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] rows;
    } t_rect;

    // First row of band k
    function automatic logic [ROW_W-1:0] band_start(input logic [BAND_W-1:0] k);
        logic [ROW_W-1:0] s;
        case (k)
            3'd0:    s = '0;
            3'd1:    s = ROW_W'(HUD_END);
            3'd2:    s = ROW_W'(HIGH_SKY_END);
            3'd3:    s = ROW_W'(MID_SKY_END);
            3'd4:    s = ROW_W'(MOUNTAIN_TOP);
            3'd5:    s = ROW_W'(GROUND_EDGE_ROW);
            3'd6:    s = ROW_W'(GROUND_EDGE_ROW + 1);
            default: s = '1;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/drbr_if.sv @@
// Handshake channel interfaces: input items, fill words and configuration writes.
interface drbr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic                          buffer_select;
    logic [drbr_pkg::XB_W-1:0]     rect_xbyte;
    logic [drbr_pkg::ROW_W-1:0]    rect_top;
    logic [drbr_pkg::WID_W-1:0]    rect_width;
    logic [drbr_pkg::ROW_W-1:0]    rect_rows;

    modport source (output valid, command, buffer_select, rect_xbyte, rect_top,
                    rect_width, rect_rows, input ready);
    modport sink   (input valid, command, buffer_select, rect_xbyte, rect_top,
                    rect_width, rect_rows, output ready);
endinterface

interface drbr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          fill_buffer;
    logic [drbr_pkg::XB_W-1:0]     fill_xbyte;
    logic [drbr_pkg::ROW_W-1:0]    fill_top;
    logic [drbr_pkg::WID_W-1:0]    fill_width;
    logic [drbr_pkg::ROW_W-1:0]    fill_rows;
    logic [drbr_pkg::WORD_W-1:0]   fill_word;
    logic                          last;

    modport source (output valid, fill_buffer, fill_xbyte, fill_top, fill_width,
                    fill_rows, fill_word, last, input ready);
    modport sink   (input valid, fill_buffer, fill_xbyte, fill_top, fill_width,
                    fill_rows, fill_word, last, output ready);
endinterface

interface drbr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [drbr_pkg::CIDX_W-1:0]   index;
    logic [drbr_pkg::WORD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/drbr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module drbr_ram #(
    parameter int WIDTH = $bits(drbr_pkg::t_rect),
    parameter int DEPTH = 2 * drbr_pkg::LIST_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/dirty_rect_band_restore_top.sv @@
// Dirty-rectangle band restore: two rectangle lists in RAM, walked into band fills.
// Add: the rectangle is trimmed and written to the list RAM in the accept cycle.
// Restore: per list entry, a registered RAM read and a capture fetch it, then one fill
//   per cycle while the output side takes words; a flush state then sends the last.
//   A fill leaves through a one-word output register after a one-word hold stage.
// Input is taken only between restores; configuration writes are taken every cycle.
// Reset (synchronous, active low) empties both lists, zeroes the band words and clears
//   the fill valid flags; RAM contents stay, and only entries below a list count are read.
module dirty_rect_band_restore_top #(
    parameter int LIST_DEPTH = drbr_pkg::LIST_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drbr_in_if.sink    i_in,
    drbr_out_if.source o_out,
    drbr_cfg_if.sink   i_cfg
);

    localparam int DEPTH = 2 * LIST_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(LIST_DEPTH + 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    drbr_pkg::t_state r_state, n_state;

    logic [CW-1:0]                r_cnt [2];
    logic [drbr_pkg::WORD_W-1:0]  r_word [drbr_pkg::NUM_CFG];

    // Walk registers
    logic                         r_sel;
    logic [CW-1:0]                r_num;
    logic [CW-1:0]                r_idx;
    logic [drbr_pkg::XB_W-1:0]    r_xb;
    logic [drbr_pkg::WID_W-1:0]   r_rw;
    logic [drbr_pkg::ROW_W-1:0]   r_y;
    logic [drbr_pkg::ROW_W-1:0]   r_y1;

    // Hold stage: the newest fill waits here until we know whether it is the last one
    logic                         r_pv;
    logic [drbr_pkg::XB_W-1:0]    r_p_xb;
    logic [drbr_pkg::ROW_W-1:0]   r_p_top;
    logic [drbr_pkg::WID_W-1:0]   r_p_rw;
    logic [drbr_pkg::ROW_W-1:0]   r_p_rows;
    logic [drbr_pkg::WORD_W-1:0]  r_p_word;

    // Output register
    logic                         r_ov;
    logic                         r_o_buf;
    logic [drbr_pkg::XB_W-1:0]    r_o_xb;
    logic [drbr_pkg::ROW_W-1:0]   r_o_top;
    logic [drbr_pkg::WID_W-1:0]   r_o_rw;
    logic [drbr_pkg::ROW_W-1:0]   r_o_rows;
    logic [drbr_pkg::WORD_W-1:0]  r_o_word;
    logic                         r_o_last;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    logic acc_in, out_take, out_free;
    logic in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign acc_in      = i_in.valid & in_ready;
    assign out_take    = r_ov & o_out.ready;
    assign out_free    = ~r_ov | o_out.ready;

    // ---------------------------------------------------------------
    // Add path: pad width to even, clamp to the row, pull x in
    // ---------------------------------------------------------------
    logic [CW-1:0]              sel_cnt;
    logic [drbr_pkg::ROW_W-1:0] add_rw;
    logic [drbr_pkg::ROW_W-1:0] add_xb;
    logic                       add_ok;
    drbr_pkg::t_rect            add_rect;

    assign sel_cnt = r_cnt[i_in.buffer_select];

    always_comb begin
        add_rw = (drbr_pkg::ROW_W'(i_in.rect_width) + 8'd1) & 8'hFE;
        if (add_rw > drbr_pkg::ROW_W'(drbr_pkg::WIDTH_LIM)) begin
            add_rw = drbr_pkg::ROW_W'(drbr_pkg::WIDTH_LIM);
        end
        add_xb = drbr_pkg::ROW_W'(i_in.rect_xbyte);
        if (add_xb + add_rw > drbr_pkg::ROW_W'(drbr_pkg::ROW_BYTES)) begin
            add_xb = drbr_pkg::ROW_W'(drbr_pkg::ROW_BYTES) - add_rw;
        end
        add_rect.xbyte = add_xb[drbr_pkg::XB_W-1:0];
        add_rect.top   = i_in.rect_top;
        add_rect.width = add_rw[drbr_pkg::WID_W-1:0];
        add_rect.rows  = i_in.rect_rows;
    end

    // Drop adds to a full list and empty rectangles
    assign add_ok = acc_in && (i_in.command == drbr_pkg::CMD_ADD)
                    && (sel_cnt < CW'(LIST_DEPTH))
                    && (i_in.rect_width != '0) && (i_in.rect_rows != '0);

    // ---------------------------------------------------------------
    // Rectangle RAM
    // ---------------------------------------------------------------
    logic [AW-1:0]   wr_addr, rd_addr, in_base, walk_base;
    logic [CW-1:0]   nxt_idx;
    drbr_pkg::t_rect rd_rect;

    assign in_base   = i_in.buffer_select ? AW'(LIST_DEPTH) : '0;
    assign walk_base = r_sel ? AW'(LIST_DEPTH) : '0;
    assign nxt_idx   = r_idx + 1'b1;
    assign wr_addr   = in_base + AW'(sel_cnt);
    // In idle, aim at the first entry of the list a restore would walk
    assign rd_addr   = (r_state == drbr_pkg::ST_IDLE) ? in_base : walk_base + AW'(nxt_idx);

    drbr_ram #(
        .WIDTH ($bits(drbr_pkg::t_rect)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (add_ok),
        .i_waddr (wr_addr),
        .i_wdata (add_rect),
        .i_raddr (rd_addr),
        .o_rdata (rd_rect)
    );

    // Clamp the fetched rectangle's bottom to the screen
    logic [drbr_pkg::ROW_W:0]   rd_sum;
    logic [drbr_pkg::ROW_W-1:0] rd_y1;

    always_comb begin
        rd_sum = (drbr_pkg::ROW_W + 1)'(rd_rect.top) + (drbr_pkg::ROW_W + 1)'(rd_rect.rows);
        if (rd_sum > (drbr_pkg::ROW_W + 1)'(drbr_pkg::SCREEN_ROWS)) begin
            rd_y1 = drbr_pkg::ROW_W'(drbr_pkg::SCREEN_ROWS);
        end else begin
            rd_y1 = rd_sum[drbr_pkg::ROW_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Run finder: band of the current row, then extend across following
    // bands while their fill words match, and stop at the rectangle bottom
    // ---------------------------------------------------------------
    logic [drbr_pkg::BAND_W-1:0] band;
    logic [drbr_pkg::ROW_W:0]    grp_end;
    logic [drbr_pkg::ROW_W-1:0]  run_end;
    logic [drbr_pkg::ROW_W-1:0]  run_rows;
    logic [drbr_pkg::WORD_W-1:0] run_word;
    logic                        have_fill;

    always_comb begin
        band = '0;
        for (int k = 1; k < drbr_pkg::NUM_CFG; k++) begin
            if (r_y >= drbr_pkg::band_start(drbr_pkg::BAND_W'(k))) begin
                band = drbr_pkg::BAND_W'(k);
            end
        end
        grp_end = {1'b1, {drbr_pkg::ROW_W{1'b0}}};
        for (int k = drbr_pkg::NUM_CFG - 2; k >= 0; k--) begin
            if (drbr_pkg::BAND_W'(k) >= band && r_word[k + 1] != r_word[k]) begin
                grp_end = {1'b0, drbr_pkg::band_start(drbr_pkg::BAND_W'(k + 1))};
            end
        end
        if ({1'b0, r_y1} < grp_end) begin
            run_end = r_y1;
        end else begin
            run_end = grp_end[drbr_pkg::ROW_W-1:0];
        end
        run_rows = run_end - r_y;
        run_word = r_word[band];
    end

    assign have_fill = (r_y < r_y1);

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            drbr_pkg::ST_IDLE: begin
                if (acc_in && i_in.command == drbr_pkg::CMD_RESTORE && sel_cnt != '0) begin
                    n_state = drbr_pkg::ST_READ;
                end
            end
            drbr_pkg::ST_READ: begin
                n_state = drbr_pkg::ST_RUN;
            end
            drbr_pkg::ST_RUN: begin
                if (!have_fill) begin
                    n_state = (nxt_idx < r_num) ? drbr_pkg::ST_READ : drbr_pkg::ST_FLUSH;
                end
            end
            drbr_pkg::ST_FLUSH: begin
                if (!r_pv || out_free) begin
                    n_state = drbr_pkg::ST_IDLE;
                end
            end
            default: n_state = drbr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: control outputs
    // ---------------------------------------------------------------
    logic cap_entry;   // fetched rectangle is on the RAM output
    logic gen;         // emit one run into the hold stage
    logic push_mid;    // hold stage moves out, more fills follow
    logic push_last;   // hold stage moves out as the final fill
    logic adv_entry;   // step to the next list entry
    logic start_rst;   // restore accepted

    always_comb begin
        in_ready  = 1'b0;
        cap_entry = 1'b0;
        gen       = 1'b0;
        push_mid  = 1'b0;
        push_last = 1'b0;
        adv_entry = 1'b0;
        start_rst = 1'b0;
        case (r_state)
            drbr_pkg::ST_IDLE: begin
                in_ready  = 1'b1;
                start_rst = acc_in && (i_in.command == drbr_pkg::CMD_RESTORE);
            end
            drbr_pkg::ST_READ: begin
                cap_entry = 1'b1;
            end
            drbr_pkg::ST_RUN: begin
                gen       = have_fill && (!r_pv || out_free);
                push_mid  = gen && r_pv;
                adv_entry = !have_fill;
            end
            drbr_pkg::ST_FLUSH: begin
                push_last = r_pv && out_free;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drbr_pkg::ST_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            for (int k = 0; k < drbr_pkg::NUM_CFG; k++) begin
                r_word[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Grow the list on an add, empty it when a restore starts
            if (add_ok) begin
                r_cnt[i_in.buffer_select] <= sel_cnt + 1'b1;
            end else if (start_rst) begin
                r_cnt[i_in.buffer_select] <= '0;
            end

            if (gen) begin
                r_pv <= 1'b1;
            end else if (push_last) begin
                r_pv <= 1'b0;
            end

            if (push_mid || push_last) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end

            // Writes beyond the register list are dropped
            if (i_cfg.valid && i_cfg.index <= drbr_pkg::CFG_GROUND) begin
                r_word[i_cfg.index] <= i_cfg.data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (start_rst) begin
            r_sel <= i_in.buffer_select;
            r_num <= sel_cnt;
            r_idx <= '0;
        end else if (adv_entry) begin
            r_idx <= nxt_idx;
        end

        if (cap_entry) begin
            r_xb <= rd_rect.xbyte;
            r_rw <= rd_rect.width;
            r_y  <= rd_rect.top;
            r_y1 <= rd_y1;
        end else if (gen) begin
            r_y <= run_end;
        end

        if (gen) begin
            r_p_xb   <= r_xb;
            r_p_top  <= r_y;
            r_p_rw   <= r_rw;
            r_p_rows <= run_rows;
            r_p_word <= run_word;
        end

        if (push_mid || push_last) begin
            r_o_buf  <= r_sel;
            r_o_xb   <= r_p_xb;
            r_o_top  <= r_p_top;
            r_o_rw   <= r_p_rw;
            r_o_rows <= r_p_rows;
            r_o_word <= r_p_word;
            r_o_last <= push_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.fill_buffer = r_o_buf;
    assign o_out.fill_xbyte  = r_o_xb;
    assign o_out.fill_top    = r_o_top;
    assign o_out.fill_width  = r_o_rw;
    assign o_out.fill_rows   = r_o_rows;
    assign o_out.fill_word   = r_o_word;
    assign o_out.last        = r_o_last;

endmodule

@@ rtl/core/drbr_check.sv @@
// Port-level checker for the dirty-rectangle band restore block, with its bind.
module drbr_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_fill_buffer,
    input logic [drbr_pkg::XB_W-1:0]         i_fill_xbyte,
    input logic [drbr_pkg::ROW_W-1:0]        i_fill_top,
    input logic [drbr_pkg::WID_W-1:0]        i_fill_width,
    input logic [drbr_pkg::ROW_W-1:0]        i_fill_rows,
    input logic [drbr_pkg::WORD_W-1:0]       i_fill_word,
    input logic                              i_last
);

    // A stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fill_buffer)
            && $stable(i_fill_xbyte) && $stable(i_fill_top) && $stable(i_fill_width)
            && $stable(i_fill_rows) && $stable(i_fill_word) && $stable(i_last))
        else $error("fill word changed while stalled");

    // Widths are padded to an even, nonzero byte count
    a_even_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_fill_width[0] && i_fill_width != '0)
        else $error("fill width odd or zero");

    // A fill is never empty and never runs past the screen bottom
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_fill_rows != '0
            && ((drbr_pkg::ROW_W + 1)'(i_fill_top) + (drbr_pkg::ROW_W + 1)'(i_fill_rows))
               <= (drbr_pkg::ROW_W + 1)'(drbr_pkg::SCREEN_ROWS))
        else $error("fill outside the screen rows");

    // Input stays closed while a restore still has fills to come
    a_busy_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input open in the middle of a restore");

endmodule

bind dirty_rect_band_restore_top drbr_check u_drbr_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_fill_buffer (o_out.fill_buffer),
    .i_fill_xbyte  (o_out.fill_xbyte),
    .i_fill_top    (o_out.fill_top),
    .i_fill_width  (o_out.fill_width),
    .i_fill_rows   (o_out.fill_rows),
    .i_fill_word   (o_out.fill_word),
    .i_last        (o_out.last)
);

@@ sim/drbr_fill_checker.sv @@
// Checker for the band restore block: predicts fill words from accepted items and compares them.
`timescale 1ns / 100ps

module drbr_fill_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    drbr_in_if   i_in,
    drbr_out_if  i_out,
    drbr_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import drbr_pkg::*;

    typedef struct packed {
        logic              fill_buffer;
        logic [XB_W-1:0]   fill_xbyte;
        logic [ROW_W-1:0]  fill_top;
        logic [WID_W-1:0]  fill_width;
        logic [ROW_W-1:0]  fill_rows;
        logic [WORD_W-1:0] fill_word;
        logic              last;
    } t_fill;

    logic [WORD_W-1:0] band_fill [NUM_CFG];
    t_rect             rect_list [2][LIST_DEPTH];
    int                list_count [2];
    t_fill             expected_fills [$];

    // Background word of one screen row
    function automatic logic [WORD_W-1:0] band_word(input int row);
        if (row < HUD_END)
            return band_fill[CFG_HUD];
        if (row < HIGH_SKY_END)
            return band_fill[CFG_HIGH_SKY];
        if (row < MID_SKY_END)
            return band_fill[CFG_MID_SKY];
        if (row < MOUNTAIN_TOP)
            return band_fill[CFG_LOW_SKY];
        if (row < GROUND_EDGE_ROW)
            return band_fill[CFG_MOUNTAIN];
        if (row == GROUND_EDGE_ROW)
            return band_fill[CFG_GROUND_EDGE];
        return band_fill[CFG_GROUND];
    endfunction

    // Pad, trim and store one rectangle; drop it if empty or the list is full
    task automatic record_rect(input logic sel, input int xb, input int top, input int w,
                               input int rows);
        int padded;
        if (list_count[sel] >= LIST_DEPTH || w == 0 || rows == 0)
            return;
        padded = (w + 1) & ~1;
        if (padded > WIDTH_LIM)
            padded = WIDTH_LIM;
        if (xb + padded > ROW_BYTES)
            xb = ROW_BYTES - padded;
        rect_list[sel][list_count[sel]] = '{xbyte: XB_W'(xb), top: ROW_W'(top),
                                            width: WID_W'(padded), rows: ROW_W'(rows)};
        list_count[sel]++;
    endtask

    // Walk one list into runs of rows sharing a band word, then empty it
    task automatic restore_fills(input logic sel);
        t_fill held;
        bit    have_held;
        int    y;
        int    y_end;
        int    r;
        logic [WORD_W-1:0] word;
        have_held = 1'b0;
        held      = '0;
        for (int i = 0; i < list_count[sel]; i++) begin
            y     = int'(rect_list[sel][i].top);
            y_end = y + int'(rect_list[sel][i].rows);
            if (y_end > SCREEN_ROWS)
                y_end = SCREEN_ROWS;
            while (y < y_end) begin
                word = band_word(y);
                r    = y + 1;
                while (r < y_end && band_word(r) == word)
                    r++;
                if (have_held)
                    expected_fills.push_back(held);
                held = '{fill_buffer: sel, fill_xbyte: rect_list[sel][i].xbyte,
                         fill_top: ROW_W'(y), fill_width: rect_list[sel][i].width,
                         fill_rows: ROW_W'(r - y), fill_word: word, last: 1'b0};
                have_held = 1'b1;
                y = r;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_fills.push_back(held);
        end
        list_count[sel] = 0;
    endtask

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_fill want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++)
                band_fill[k] = '0;
            list_count[0] = 0;
            list_count[1] = 0;
            expected_fills.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready && i_cfg.index < NUM_CFG)
                band_fill[i_cfg.index] = i_cfg.data;
            if (i_out.valid && i_out.ready) begin
                if (expected_fills.size() == 0) begin
                    $error("unexpected fill word: top %0d rows %0d", i_out.fill_top,
                           i_out.fill_rows);
                    o_fail_count++;
                end else begin
                    want = expected_fills.pop_front();
                    check_field("fill_buffer", want.fill_buffer, i_out.fill_buffer);
                    check_field("fill_xbyte", want.fill_xbyte, i_out.fill_xbyte);
                    check_field("fill_top", want.fill_top, i_out.fill_top);
                    check_field("fill_width", want.fill_width, i_out.fill_width);
                    check_field("fill_rows", want.fill_rows, i_out.fill_rows);
                    check_field("fill_word", want.fill_word, i_out.fill_word);
                    check_field("last", want.last, i_out.last);
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.command == CMD_ADD)
                    record_rect(i_in.buffer_select, int'(i_in.rect_xbyte), int'(i_in.rect_top),
                                int'(i_in.rect_width), int'(i_in.rect_rows));
                else
                    restore_fills(i_in.buffer_select);
            end
        end
        o_pending = expected_fills.size();
    end

endmodule

@@ sim/dirty_rect_band_restore_top_tb.sv @@
// Testbench top for the band restore block: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module dirty_rect_band_restore_top_tb;
    import drbr_pkg::*;

    localparam int DRAIN_CYCLES = 64;    // covers a restore walking a list with no fills
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on any channel
    localparam int LONG_HOLD    = 150;   // one long output stall to back the block up
    localparam int PHASE_ITEMS  = 75;
    localparam int NUM_PHASES   = 4;

    // Index past the last band register; the block must ignore writes to it
    localparam logic [CIDX_W-1:0] CFG_SPARE = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    drbr_in_if  in_ch ();
    drbr_out_if out_ch ();
    drbr_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int gap_pct      = 0;   // chance in percent of an idle burst on either side
    bit hold_pending = 1'b0;

    dirty_rect_band_restore_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    drbr_fill_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: give up once nothing has moved on any channel for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Fill word receiver: short random stalls, plus one long hold-off on request.
    // Each pass assigns ready once, at the edge it starts on.
    always begin
        @(posedge i_clk);
        if (hold_pending) begin
            hold_pending = 1'b0;
            out_ch.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge i_clk);
        end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Offer one input word and hold it until the block takes it. Valid is left high
    // afterwards; the next call either idles first or replaces the word directly.
    task automatic send_item(input logic cmd, input logic sel, input logic [XB_W-1:0] xb,
                             input logic [ROW_W-1:0] top, input logic [WID_W-1:0] w,
                             input logic [ROW_W-1:0] rows);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.buffer_select <= sel;
        in_ch.rect_xbyte    <= xb;
        in_ch.rect_top      <= top;
        in_ch.rect_width    <= w;
        in_ch.rect_rows     <= rows;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Restore with random bits in the fields the block should ignore
    task automatic send_restore(input logic sel);
        send_item(CMD_RESTORE, sel, XB_W'($urandom_range(0, 127)),
                  ROW_W'($urandom_range(0, 255)), WID_W'($urandom_range(0, 127)),
                  ROW_W'($urandom_range(0, 255)));
    endtask

    // Add with mostly legal geometry, now and then out of range or empty
    task automatic send_rand_add(input logic sel);
        int xb;
        int top;
        int w;
        int rows;
        int pick;
        xb   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 79);
        top  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 199);
        pick = $urandom_range(0, 19);
        w    = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(81, 127) : $urandom_range(1, 80);
        pick = $urandom_range(0, 19);
        rows = (pick < 2) ? 0 : (pick < 11) ? $urandom_range(1, 40) : $urandom_range(1, 255);
        send_item(CMD_ADD, sel, XB_W'(xb), ROW_W'(top), WID_W'(w), ROW_W'(rows));
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write every band register, poke the unused index, then drop valid
    task automatic load_bands(input logic [WORD_W-1:0] words [NUM_CFG]);
        for (int k = 0; k < NUM_CFG; k++)
            write_reg(t_cfg_idx'(k), words[k]);
        write_reg(CFG_SPARE, WORD_W'($urandom_range(0, 65535)));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering, wait for every predicted fill, then let a fill-less restore finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [WORD_W-1:0] words [NUM_CFG];
        int   items;
        int   n_adds;
        logic sel;

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.command       <= CMD_ADD;
        in_ch.buffer_select <= 1'b0;
        in_ch.rect_xbyte    <= '0;
        in_ch.rect_top      <= '0;
        in_ch.rect_width    <= '0;
        in_ch.rect_rows     <= '0;
        out_ch.ready        <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_HUD;
        cfg_ch.data         <= '0;
        gap_pct = 25;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset band words are all zero: a full-screen rectangle is one run
        send_item(CMD_ADD, 1'b0, 7'd0, 8'd0, 7'd80, 8'd200);
        send_restore(1'b0);
        drain();

        words = '{16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h0000};
        load_bands(words);

        // Directed corners, one list filled past its depth
        send_restore(1'b0);                                       // empty list
        send_item(CMD_ADD, 1'b0, 7'd0, 8'd0, 7'd80, 8'd200);      // every band
        send_item(CMD_ADD, 1'b0, 7'd79, 8'd5, 7'd1, 8'd3);        // pad to 2, pull left
        send_item(CMD_ADD, 1'b0, 7'd127, 8'd255, 7'd127, 8'd255); // width cap, off screen
        send_item(CMD_ADD, 1'b0, 7'd10, 8'd10, 7'd0, 8'd5);       // zero width: drop
        send_item(CMD_ADD, 1'b0, 7'd10, 8'd10, 7'd5, 8'd0);       // zero rows: drop
        send_item(CMD_ADD, 1'b0, 7'd33, 8'd168, 7'd9, 8'd10);     // sky to ground
        send_item(CMD_ADD, 1'b1, 7'd5, 8'd200, 7'd4, 8'd4);       // starts at screen end
        send_item(CMD_ADD, 1'b0, 7'd0, 8'd199, 7'd2, 8'd255);     // clamp to one row
        send_item(CMD_ADD, 1'b0, 7'd20, 8'd60, 7'd3, 8'd70);      // three sky bands
        send_item(CMD_ADD, 1'b0, 7'd41, 8'd7, 7'd79, 8'd2);       // hud edge, full row
        send_item(CMD_ADD, 1'b0, 7'd40, 8'd174, 7'd40, 8'd1);     // ground edge row only
        send_item(CMD_ADD, 1'b0, 7'd1, 8'd1, 7'd1, 8'd1);         // list full: drop
        // Hold off the receiver while this many-fill restore walks and inputs keep coming
        hold_pending = 1'b1;
        send_restore(1'b0);
        send_restore(1'b1);                                       // nothing to fill
        send_restore(1'b1);                                       // list already empty
        send_item(CMD_ADD, 1'b1, 7'd64, 8'd119, 7'd16, 8'd2);     // mid/low sky boundary
        send_restore(1'b1);
        drain();

        // Random phases: mostly add runs closed by a restore, some raw noise words.
        // The last phase runs without any idling.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                case (phase)
                    0:       words[k] = WORD_W'($urandom_range(0, 65535));
                    1:       words[k] = 16'hFFFF;
                    2:       words[k] = $urandom_range(0, 1) ? 16'hA5A5 : 16'h5A5A;
                    default: words[k] = 16'h0000;
                endcase
            end
            load_bands(words);
            gap_pct = (phase == NUM_PHASES - 1) ? 0 : (phase == 0) ? 30 : 10;
            items   = 0;
            while (items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8) begin
                    sel    = 1'($urandom_range(0, 1));
                    n_adds = $urandom_range(1, LIST_DEPTH + 2);
                    repeat (n_adds) begin
                        send_rand_add(($urandom_range(0, 4) == 0) ? !sel : sel);
                        items++;
                    end
                    send_restore(sel);
                    items++;
                end else begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              XB_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 255)),
                              WID_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 255)));
                    items++;
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/drbr_pkg.sv
rtl/core/drbr_if.sv
rtl/core/drbr_ram.sv
rtl/core/dirty_rect_band_restore_top.sv
rtl/core/drbr_check.sv
sim/drbr_fill_checker.sv
sim/dirty_rect_band_restore_top_tb.sv
